// File: hdl/sadg_pkg.sv
`default_nettype none

package sadg_pkg;

    // Level numbers and level totals are four bits wide: numbers 0 to 15, totals up to 15.
    localparam int LVL_BITS = 4;
    localparam int TOT_BITS = 4;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e;

    // Operation carried by a token as it travels down the row of level cells.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_NEXT  = 2'd3
    } op_e;

    typedef logic [LVL_BITS-1:0] lvl_t;
    typedef logic [31:0]         word32_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         level;
        logic [23:0]        count;
        logic signed [31:0] src_offset;
        logic signed [31:0] dst_offset;
        logic signed [31:0] src_stride;
        logic signed [31:0] dst_stride;
        logic [31:0]        src_base;
        logic [31:0]        dst_base;
        logic [2:0]         first_level;
        logic [3:0]         level_total;
    } req_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        last;
    } rsp_t;

    // Descriptor data that rides along with a load token.
    typedef struct packed {
        logic signed [31:0] src_offset;
        logic signed [31:0] dst_offset;
        logic signed [31:0] src_stride;
        logic signed [31:0] dst_stride;
    } wr_t;

    // Control part of a token. For a load, lvl is the target level; for a start, it is
    // the first level; for a next, it is the level that steps. inner is the innermost level.
    typedef struct packed {
        op_e  op;
        lvl_t lvl;
        lvl_t inner;
        logic fin;
    } ctl_t;

endpackage

`default_nettype wire

// File: hdl/sadg_ctrl.sv
`default_nettype none

module sadg_ctrl #(
    parameter int MAX_LEVELS = 8,
    parameter int ADDR_BITS  = 32,
    parameter int COUNT_BITS = 24
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   take,
    input  wire                   adv,
    input  wire sadg_pkg::req_t   req,
    output sadg_pkg::ctl_t        ctl,
    output sadg_pkg::wr_t         wr,
    output logic [ADDR_BITS-1:0]  src_bus,
    output logic [ADDR_BITS-1:0]  dst_bus
);

    localparam int CW1 = COUNT_BITS + 1;

    logic [COUNT_BITS-1:0]         cnt_reg  [MAX_LEVELS];
    logic [COUNT_BITS-1:0]         cnt_next [MAX_LEVELS];
    logic [COUNT_BITS-1:0]         idx_reg  [MAX_LEVELS];
    logic [COUNT_BITS-1:0]         idx_next [MAX_LEVELS];
    sadg_pkg::lvl_t                first_reg, first_next;
    logic [sadg_pkg::TOT_BITS-1:0] total_reg, total_next;
    logic                          running_reg, running_next;

    sadg_pkg::ctl_t                ctl_reg, ctl_next;
    sadg_pkg::wr_t                 wr_reg, wr_next;
    logic [ADDR_BITS-1:0]          src_bus_reg, src_bus_next;
    logic [ADDR_BITS-1:0]          dst_bus_reg, dst_bus_next;

    logic [sadg_pkg::TOT_BITS-1:0] total_sat;
    logic                          start_empty;
    logic [MAX_LEVELS-1:0]         more;
    logic                          any_more;
    sadg_pkg::lvl_t                step_lvl;

    // Start checks and the search for the deepest level that can still step.
    always_comb
    begin
        if (int'(req.level_total) > MAX_LEVELS)
            total_sat = sadg_pkg::TOT_BITS'(MAX_LEVELS);
        else
            total_sat = req.level_total;

        start_empty = !(int'(req.first_level) < int'(total_sat));
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            if (l >= int'(req.first_level) && l < int'(total_sat) && cnt_reg[l] == '0)
                start_empty = 1'b1;
        end

        any_more = 1'b0;
        step_lvl = '0;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            more[l] = (l >= int'(first_reg)) && (l < int'(total_reg)) && (cnt_reg[l] != '0) &&
                      ((CW1'(idx_reg[l]) + CW1'(1)) < CW1'(cnt_reg[l]));
            if (more[l])
            begin
                any_more = 1'b1;
                step_lvl = sadg_pkg::lvl_t'(l);
            end
        end
    end

    // Next state and the token handed to the first cell.
    always_comb
    begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        first_next   = first_reg;
        total_next   = total_reg;
        running_next = running_reg;
        ctl_next     = '0;
        ctl_next.op  = sadg_pkg::OP_NONE;
        wr_next      = wr_reg;
        src_bus_next = src_bus_reg;
        dst_bus_next = dst_bus_reg;

        if (take)
        begin
            case (req.cmd)
                sadg_pkg::CMD_LOAD:
                begin
                    for (int l = 0; l < MAX_LEVELS; l++)
                    begin
                        if (int'(req.level) == l)
                            cnt_next[l] = COUNT_BITS'(req.count);
                    end
                    ctl_next.op        = sadg_pkg::OP_LOAD;
                    ctl_next.lvl       = sadg_pkg::lvl_t'(req.level);
                    wr_next.src_offset = req.src_offset;
                    wr_next.dst_offset = req.dst_offset;
                    wr_next.src_stride = req.src_stride;
                    wr_next.dst_stride = req.dst_stride;
                end
                sadg_pkg::CMD_START:
                begin
                    first_next   = sadg_pkg::lvl_t'(req.first_level);
                    total_next   = total_sat;
                    running_next = 1'b0;
                    if (!start_empty)
                    begin
                        running_next = 1'b1;
                        for (int l = 0; l < MAX_LEVELS; l++)
                            idx_next[l] = '0;
                        ctl_next.op    = sadg_pkg::OP_START;
                        ctl_next.lvl   = sadg_pkg::lvl_t'(req.first_level);
                        ctl_next.inner = sadg_pkg::lvl_t'(total_sat - sadg_pkg::TOT_BITS'(1));
                        src_bus_next   = ADDR_BITS'(req.src_base);
                        dst_bus_next   = ADDR_BITS'(req.dst_base);
                    end
                end
                sadg_pkg::CMD_NEXT:
                begin
                    if (running_reg)
                    begin
                        ctl_next.op    = sadg_pkg::OP_NEXT;
                        ctl_next.lvl   = step_lvl;
                        ctl_next.inner = sadg_pkg::lvl_t'(total_reg - sadg_pkg::TOT_BITS'(1));
                        ctl_next.fin   = !any_more;
                        if (!any_more)
                            running_next = 1'b0;
                        else
                        begin
                            for (int l = 0; l < MAX_LEVELS; l++)
                            begin
                                if (sadg_pkg::lvl_t'(l) == step_lvl)
                                    idx_next[l] = idx_reg[l] + COUNT_BITS'(1);
                                else if (sadg_pkg::lvl_t'(l) > step_lvl && l < int'(total_reg))
                                    idx_next[l] = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
                idx_reg[l] <= '0;
            first_reg   <= '0;
            total_reg   <= sadg_pkg::TOT_BITS'(1);
            running_reg <= 1'b0;
            ctl_reg     <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            first_reg   <= first_next;
            total_reg   <= total_next;
            running_reg <= running_next;
            if (adv)
                ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (adv)
        begin
            wr_reg      <= wr_next;
            src_bus_reg <= src_bus_next;
            dst_bus_reg <= dst_bus_next;
        end
    end

    assign ctl     = ctl_reg;
    assign wr      = wr_reg;
    assign src_bus = src_bus_reg;
    assign dst_bus = dst_bus_reg;

    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (first_reg < sadg_pkg::lvl_t'(total_reg)))
        else $error("running with first level not below level total");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req.cmd == sadg_pkg::CMD_NEXT && running_reg && !any_more) |=> !running_reg)
        else $error("transfer still running after its final pair");

    a_next_token: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req.cmd == sadg_pkg::CMD_NEXT && running_reg) |=> (ctl_reg.op == sadg_pkg::OP_NEXT))
        else $error("accepted next request did not issue a token");

endmodule

`default_nettype wire

// File: hdl/sadg_cell.sv
`default_nettype none

module sadg_cell #(
    parameter int IDX       = 0,
    parameter int ADDR_BITS = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         adv,
    input  wire sadg_pkg::ctl_t         ctl_in,
    input  wire sadg_pkg::wr_t          wr_in,
    input  wire [ADDR_BITS-1:0]         src_bus_in,
    input  wire [ADDR_BITS-1:0]         dst_bus_in,
    input  wire [ADDR_BITS-1:0]         src_cap_in,
    input  wire [ADDR_BITS-1:0]         dst_cap_in,
    output sadg_pkg::ctl_t              ctl_out,
    output sadg_pkg::wr_t               wr_out,
    output logic [ADDR_BITS-1:0]        src_bus_out,
    output logic [ADDR_BITS-1:0]        dst_bus_out,
    output logic [ADDR_BITS-1:0]        src_cap_out,
    output logic [ADDR_BITS-1:0]        dst_cap_out
);

    localparam sadg_pkg::lvl_t MY_LVL = sadg_pkg::lvl_t'(IDX);

    logic signed [31:0]   src_off_reg, src_off_next;
    logic signed [31:0]   dst_off_reg, dst_off_next;
    logic signed [31:0]   src_stride_reg, src_stride_next;
    logic signed [31:0]   dst_stride_reg, dst_stride_next;
    logic [ADDR_BITS-1:0] src_pos_reg, src_pos_next;
    logic [ADDR_BITS-1:0] dst_pos_reg, dst_pos_next;

    sadg_pkg::ctl_t       ctl_reg;
    sadg_pkg::wr_t        wr_reg;
    logic [ADDR_BITS-1:0] src_bus_reg, src_bus_next;
    logic [ADDR_BITS-1:0] dst_bus_reg, dst_bus_next;
    logic [ADDR_BITS-1:0] src_cap_reg, src_cap_next;
    logic [ADDR_BITS-1:0] dst_cap_reg, dst_cap_next;

    always_comb
    begin
        src_off_next    = src_off_reg;
        dst_off_next    = dst_off_reg;
        src_stride_next = src_stride_reg;
        dst_stride_next = dst_stride_reg;
        src_pos_next    = src_pos_reg;
        dst_pos_next    = dst_pos_reg;
        src_bus_next    = src_bus_in;
        dst_bus_next    = dst_bus_in;
        src_cap_next    = src_cap_in;
        dst_cap_next    = dst_cap_in;

        case (ctl_in.op)
            sadg_pkg::OP_LOAD:
            begin
                if (ctl_in.lvl == MY_LVL)
                begin
                    src_off_next    = wr_in.src_offset;
                    dst_off_next    = wr_in.dst_offset;
                    src_stride_next = wr_in.src_stride;
                    dst_stride_next = wr_in.dst_stride;
                end
            end
            sadg_pkg::OP_START:
            begin
                if (MY_LVL >= ctl_in.lvl && MY_LVL <= ctl_in.inner)
                begin
                    src_pos_next = src_bus_in + ADDR_BITS'(src_off_reg);
                    dst_pos_next = dst_bus_in + ADDR_BITS'(dst_off_reg);
                    src_bus_next = src_pos_next;
                    dst_bus_next = dst_pos_next;
                end
            end
            sadg_pkg::OP_NEXT:
            begin
                // The innermost level hands out its position as it stood before this step.
                if (MY_LVL == ctl_in.inner)
                begin
                    src_cap_next = src_pos_reg;
                    dst_cap_next = dst_pos_reg;
                end
                if (!ctl_in.fin)
                begin
                    if (MY_LVL < ctl_in.lvl)
                    begin
                        src_bus_next = src_pos_reg;
                        dst_bus_next = dst_pos_reg;
                    end
                    else if (MY_LVL == ctl_in.lvl)
                    begin
                        src_pos_next = src_pos_reg + ADDR_BITS'(src_stride_reg);
                        dst_pos_next = dst_pos_reg + ADDR_BITS'(dst_stride_reg);
                        src_bus_next = src_pos_next;
                        dst_bus_next = dst_pos_next;
                    end
                    else if (MY_LVL <= ctl_in.inner)
                    begin
                        src_pos_next = src_bus_in + ADDR_BITS'(src_off_reg);
                        dst_pos_next = dst_bus_in + ADDR_BITS'(dst_off_reg);
                        src_bus_next = src_pos_next;
                        dst_bus_next = dst_pos_next;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_pos_reg <= '0;
            dst_pos_reg <= '0;
            ctl_reg     <= '0;
        end
        else if (adv)
        begin
            src_pos_reg <= src_pos_next;
            dst_pos_reg <= dst_pos_next;
            ctl_reg     <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            src_off_reg    <= src_off_next;
            dst_off_reg    <= dst_off_next;
            src_stride_reg <= src_stride_next;
            dst_stride_reg <= dst_stride_next;
            wr_reg         <= wr_in;
            src_bus_reg    <= src_bus_next;
            dst_bus_reg    <= dst_bus_next;
            src_cap_reg    <= src_cap_next;
            dst_cap_reg    <= dst_cap_next;
        end
    end

    assign ctl_out     = ctl_reg;
    assign wr_out      = wr_reg;
    assign src_bus_out = src_bus_reg;
    assign dst_bus_out = dst_bus_reg;
    assign src_cap_out = src_cap_reg;
    assign dst_cap_out = dst_cap_reg;

endmodule

`default_nettype wire

// File: hdl/sadg_outq.sv
`default_nettype none

module sadg_outq (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire sadg_pkg::rsp_t din,
    input  wire                 pop,
    output logic                valid,
    output sadg_pkg::rsp_t      dout,
    output logic                full
);

    sadg_pkg::rsp_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    assign valid = (count_reg != 2'd0);
    assign full  = (count_reg == 2'd2);
    assign dout  = slot_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("result word pushed into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd3))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

// File: hdl/strided_nd_copy_address_generator.sv
// Path: a next request accepted by the head passes through one head register, one register
// per level cell and one output queue slot, from which its result word is offered.
// Throughput: one request word per cycle; the output queue holds two result words and
// the request side stalls only while both slots are occupied.
// Reset (rst_n, asynchronous, active low) leaves the block idle with level total one,
// first level zero and positions zero; level descriptors stay undefined until loaded.
`default_nettype none

module strided_nd_copy_address_generator #(
    parameter int MAX_LEVELS = 8,
    parameter int ADDR_BITS  = 32,
    parameter int COUNT_BITS = 24
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire sadg_pkg::req_t req_word,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output sadg_pkg::rsp_t      rsp_word
);

    // The design is a head controller followed by a row of level cells, one per level.
    // The head owns the iteration counts and indices: on each next request while a transfer
    // runs it finds the deepest level that can still step and sends a token down the row.
    // Each cell owns the offsets, strides and current positions of its level. A token reaches
    // cell l through the output register of cell l-1, so a cell that re-enters its level sees
    // the parent position its neighbor has just computed for the same token. Tokens never
    // overtake each other, so descriptor loads and starts take effect in request order.
    //
    // The position of the innermost level before the step is captured on the way and
    // becomes the result word. Every stage moves together; the row only pauses while
    // the output queue is full.

    logic                 adv;
    logic                 take;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    sadg_pkg::rsp_t       q_din;

    sadg_pkg::ctl_t       ctl_c    [MAX_LEVELS+1];
    sadg_pkg::wr_t        wr_c     [MAX_LEVELS+1];
    logic [ADDR_BITS-1:0] src_bus_c[MAX_LEVELS+1];
    logic [ADDR_BITS-1:0] dst_bus_c[MAX_LEVELS+1];
    logic [ADDR_BITS-1:0] src_cap_c[MAX_LEVELS+1];
    logic [ADDR_BITS-1:0] dst_cap_c[MAX_LEVELS+1];

    // Stall comes from registered queue state only, so no path runs from rsp_stall
    // to req_stall.
    assign adv       = !q_full;
    assign req_stall = q_full;
    assign take      = req_valid && !req_stall;

    sadg_ctrl #(
        .MAX_LEVELS (MAX_LEVELS),
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .adv     (adv),
        .req     (req_word),
        .ctl     (ctl_c[0]),
        .wr      (wr_c[0]),
        .src_bus (src_bus_c[0]),
        .dst_bus (dst_bus_c[0])
    );

    assign src_cap_c[0] = '0;
    assign dst_cap_c[0] = '0;

    for (genvar g = 0; g < MAX_LEVELS; g++)
    begin : g_cell
        sadg_cell #(
            .IDX       (g),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .ctl_in      (ctl_c[g]),
            .wr_in       (wr_c[g]),
            .src_bus_in  (src_bus_c[g]),
            .dst_bus_in  (dst_bus_c[g]),
            .src_cap_in  (src_cap_c[g]),
            .dst_cap_in  (dst_cap_c[g]),
            .ctl_out     (ctl_c[g+1]),
            .wr_out      (wr_c[g+1]),
            .src_bus_out (src_bus_c[g+1]),
            .dst_bus_out (dst_bus_c[g+1]),
            .src_cap_out (src_cap_c[g+1]),
            .dst_cap_out (dst_cap_c[g+1])
        );
    end

    // Only a next token that leaves the last cell produces a result word.
    assign q_push         = adv && (ctl_c[MAX_LEVELS].op == sadg_pkg::OP_NEXT);
    assign q_din.src_addr = sadg_pkg::word32_t'(src_cap_c[MAX_LEVELS]);
    assign q_din.dst_addr = sadg_pkg::word32_t'(dst_cap_c[MAX_LEVELS]);
    assign q_din.last     = ctl_c[MAX_LEVELS].fin;
    assign q_pop          = rsp_valid && !rsp_stall;

    sadg_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .valid (rsp_valid),
        .dout  (rsp_word),
        .full  (q_full)
    );

endmodule

`default_nettype wire
